// ===== rtl/rbeh_pkg.sv =====
`default_nettype none
package rbeh_pkg;

	localparam int FRAC_BITS_DEF    = 16;
	localparam int CORDIC_STEPS_DEF = 18;
	localparam int ATAN_ENTRIES     = 30;
	localparam int STEP_W           = 7;
	localparam int DIV_STEPS        = 66;
	localparam int ZW               = 35;
	localparam int CW               = 33;

	localparam longint Q30_PI      = 64'sd3373259426;
	localparam longint Q30_HALF_PI = 64'sd1686629713;
	localparam longint Q30_TWO_PI  = 64'sd6746518852;
	localparam longint Q30_GAIN    = 64'sd652032874;

	localparam logic [3:0] REG_CENTER_X   = 4'd0;
	localparam logic [3:0] REG_CENTER_Y   = 4'd1;
	localparam logic [3:0] REG_BOX_WIDTH  = 4'd2;
	localparam logic [3:0] REG_BOX_LENGTH = 4'd3;

	localparam logic [4:0] OP_IDLE  = 5'd0;
	localparam logic [4:0] OP_LOAD  = 5'd1;
	localparam logic [4:0] OP_RED   = 5'd2;
	localparam logic [4:0] OP_FOLD  = 5'd3;
	localparam logic [4:0] OP_HALF  = 5'd4;
	localparam logic [4:0] OP_ROT   = 5'd5;
	localparam logic [4:0] OP_FLIP  = 5'd6;
	localparam logic [4:0] OP_EDGE  = 5'd7;
	localparam logic [4:0] OP_NUM   = 5'd8;
	localparam logic [4:0] OP_CHK   = 5'd9;
	localparam logic [4:0] OP_MUL0  = 5'd10;
	localparam logic [4:0] OP_MUL1  = 5'd11;
	localparam logic [4:0] OP_DQI   = 5'd12;
	localparam logic [4:0] OP_DQ    = 5'd13;
	localparam logic [4:0] OP_QCHK  = 5'd14;
	localparam logic [4:0] OP_QTEST = 5'd15;
	localparam logic [4:0] OP_DTI   = 5'd16;
	localparam logic [4:0] OP_DT    = 5'd17;
	localparam logic [4:0] OP_TDONE = 5'd18;
	localparam logic [4:0] OP_OUT   = 5'd19;

	typedef struct packed {
		logic [4:0]        op;
		logic [STEP_W-1:0] step;
		logic [1:0]        edge_sel;
	} rbeh_cmd_t;

	typedef struct packed {
		logic skip;
		logic inrange;
	} rbeh_stat_t;

	function automatic int red_steps(input int frac_bits);
		int aw;
		aw = 50 - frac_bits;
		return (aw > 33) ? (aw - 32) : 1;
	endfunction

	function automatic logic [30:0] atan_q30(input logic [4:0] i);
		logic [30:0] v;
		case (i)
			5'd0: v = 31'd843314857;
			5'd1: v = 31'd497837829;
			5'd2: v = 31'd263043837;
			5'd3: v = 31'd133525159;
			5'd4: v = 31'd67021687;
			5'd5: v = 31'd33543516;
			5'd6: v = 31'd16775851;
			5'd7: v = 31'd8388437;
			5'd8: v = 31'd4194283;
			5'd9: v = 31'd2097149;
			default: v = 31'd1 << (5'd30 - i);
		endcase
		return v;
	endfunction

	function automatic logic [31:0] sat32(input logic [32:0] v);
		logic [31:0] r;
		if (v[32] != v[31]) begin
			r = v[32] ? 32'h8000_0000 : 32'h7fff_ffff;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/ray_box_edge_hit_core.sv =====
// Ray against box edge intersection core.
// Box registers are written through the cfg channel (cfg_valid, cfg_ready,
// cfg_index, cfg_data); cfg_ready is always high. Index 0 is center_x, 1 is
// center_y, 2 is box_width and 3 is box_length; other indexes are ignored.
// A ray is taken when start is high and busy is low. The core then runs one
// ray at a time and holds busy high until the result is shown.
// The result appears on hit_valid, hit_distance, hit_x and hit_y, marked by done,
// which is high for exactly one cycle. The receiver cannot stall the core.
// Done follows the angle reduction (2 steps for 16 fraction bits), the CORDIC
// rotation and, per box edge, a skip test, a division for the hit point unless
// the edge is skipped and a second division for the distance when the hit lies
// on the edge. A new ray may start while done is high.
// The time is set by the shared one-bit-per-cycle divider, which runs up to
// two 66-step divisions per edge, and by the one-step CORDIC unit.
// Reset clears the controller and puts the box at the origin with unit size.
`default_nettype none
module ray_box_edge_hit_core import rbeh_pkg::*; #(
	parameter int FRAC_BITS    = FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] origin_x,
	input  wire logic signed [31:0] origin_y,
	input  wire logic signed [19:0] ray_angle,
	output logic                    done,
	output logic                    hit_valid,
	output logic signed [31:0]      hit_distance,
	output logic signed [31:0]      hit_x,
	output logic signed [31:0]      hit_y,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [3:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);

	localparam logic [30:0] UNIT = 31'(64'sd1 <<< FRAC_BITS);

	logic signed [31:0] center_x_q, center_y_q;
	logic [30:0]        box_width_q, box_length_q;
	logic signed [32:0] xr, xl, yt, yb;
	rbeh_cmd_t          cmd;
	rbeh_stat_t         stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q   <= '0;
			center_y_q   <= '0;
			box_width_q  <= UNIT;
			box_length_q <= UNIT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CENTER_X:   center_x_q   <= cfg_data;
				REG_CENTER_Y:   center_y_q   <= cfg_data;
				REG_BOX_WIDTH:  box_width_q  <= cfg_data[30:0];
				REG_BOX_LENGTH: box_length_q <= cfg_data[30:0];
				default: begin
				end
			endcase
		end
	end

	assign xr = $signed(33'(center_x_q)) + $signed({3'b000, box_length_q[30:1]});
	assign xl = $signed(33'(center_x_q)) - $signed({3'b000, box_length_q[30:1]});
	assign yt = $signed(33'(center_y_q)) + $signed({3'b000, box_width_q[30:1]});
	assign yb = $signed(33'(center_y_q)) - $signed({3'b000, box_width_q[30:1]});

	rbeh_ctrl #(
		.FRAC_BITS   (FRAC_BITS),
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.stat  (stat),
		.cmd   (cmd)
	);

	rbeh_dp #(
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.origin_x    (origin_x),
		.origin_y    (origin_y),
		.ray_angle   (ray_angle),
		.xr          (xr),
		.xl          (xl),
		.yt          (yt),
		.yb          (yb),
		.done        (done),
		.hit_valid   (hit_valid),
		.hit_distance(hit_distance),
		.hit_x       (hit_x),
		.hit_y       (hit_y)
	);

endmodule
`default_nettype wire

// ===== rtl/rbeh_ctrl.sv =====
`default_nettype none
module rbeh_ctrl import rbeh_pkg::*; #(
	parameter int FRAC_BITS    = FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire rbeh_stat_t stat,
	output rbeh_cmd_t       cmd
);

	localparam int RED_STEPS = red_steps(FRAC_BITS);
	localparam int CS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
	localparam logic [STEP_W-1:0] RED_LAST = STEP_W'(RED_STEPS - 1);
	localparam logic [STEP_W-1:0] ROT_LAST = STEP_W'(CS - 1);
	localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);

	logic [4:0]        state_q, state_d;
	logic [STEP_W-1:0] cnt_q, cnt_d;
	logic [1:0]        edge_q, edge_d;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		edge_d  = edge_q;
		case (state_q)
			OP_IDLE: begin
				if (start) begin
					state_d = OP_RED;
					cnt_d   = '0;
				end
			end
			OP_RED: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == RED_LAST) begin
					state_d = OP_FOLD;
				end
			end
			OP_FOLD: state_d = OP_HALF;
			OP_HALF: begin
				state_d = OP_ROT;
				cnt_d   = '0;
			end
			OP_ROT: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == ROT_LAST) begin
					state_d = OP_FLIP;
				end
			end
			OP_FLIP: begin
				state_d = OP_EDGE;
				edge_d  = 2'd0;
			end
			OP_EDGE: state_d = OP_NUM;
			OP_NUM:  state_d = OP_CHK;
			OP_CHK: begin
				if (stat.skip) begin
					state_d = (edge_q == 2'd3) ? OP_OUT : OP_EDGE;
					edge_d  = edge_q + 1'b1;
				end else begin
					state_d = OP_MUL0;
				end
			end
			OP_MUL0: state_d = OP_MUL1;
			OP_MUL1: state_d = OP_DQI;
			OP_DQI: begin
				state_d = OP_DQ;
				cnt_d   = '0;
			end
			OP_DQ: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == DIV_LAST) begin
					state_d = OP_QCHK;
				end
			end
			OP_QCHK: state_d = OP_QTEST;
			OP_QTEST: begin
				if (stat.inrange) begin
					state_d = OP_DTI;
				end else begin
					state_d = (edge_q == 2'd3) ? OP_OUT : OP_EDGE;
					edge_d  = edge_q + 1'b1;
				end
			end
			OP_DTI: begin
				state_d = OP_DT;
				cnt_d   = '0;
			end
			OP_DT: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == DIV_LAST) begin
					state_d = OP_TDONE;
				end
			end
			OP_TDONE: begin
				state_d = (edge_q == 2'd3) ? OP_OUT : OP_EDGE;
				edge_d  = edge_q + 1'b1;
			end
			OP_OUT:  state_d = OP_IDLE;
			default: state_d = OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= OP_IDLE;
			cnt_q   <= '0;
			edge_q  <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			edge_q  <= edge_d;
		end
	end

	assign busy         = (state_q != OP_IDLE);
	assign cmd.op       = (state_q == OP_IDLE && start) ? OP_LOAD : state_q;
	assign cmd.step     = cnt_q;
	assign cmd.edge_sel = edge_q;

endmodule
`default_nettype wire

// ===== rtl/rbeh_dp.sv =====
`default_nettype none
module rbeh_dp import rbeh_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rbeh_cmd_t          cmd,
	output rbeh_stat_t              stat,
	input  wire logic signed [31:0] origin_x,
	input  wire logic signed [31:0] origin_y,
	input  wire logic signed [19:0] ray_angle,
	input  wire logic signed [32:0] xr,
	input  wire logic signed [32:0] xl,
	input  wire logic signed [32:0] yt,
	input  wire logic signed [32:0] yb,
	output logic                    done,
	output logic                    hit_valid,
	output logic signed [31:0]      hit_distance,
	output logic signed [31:0]      hit_x,
	output logic signed [31:0]      hit_y
);

	localparam int SH        = 30 - FRAC_BITS;
	localparam int ANG_W     = 20 + SH;
	localparam int RED_STEPS = red_steps(FRAC_BITS);
	localparam int RW        = ((ANG_W > 34) ? ANG_W : 34) + 1;
	localparam logic [RW-1:0] DIV_INIT = RW'(Q30_TWO_PI) << (RED_STEPS - 1);
	localparam logic [31:0]   NEG_ONE  = 32'(-(64'sd1 <<< FRAC_BITS));
	localparam logic signed [ZW-1:0] PI_Z  = ZW'(Q30_PI);
	localparam logic signed [ZW-1:0] HPI_Z = ZW'(Q30_HALF_PI);
	localparam logic signed [ZW-1:0] TPI_Z = ZW'(Q30_TWO_PI);

	logic signed [31:0]    ox_q, oy_q;
	logic [RW-1:0]         mag_q, div_q;
	logic                  zneg_q, flip_q;
	logic signed [ZW-1:0]  z_q;
	logic signed [CW-1:0]  x_q, y_q;
	logic signed [32:0]    e_q, lo_q, hi_q;
	logic signed [31:0]    oacr_q, oalg_q;
	logic signed [CW-1:0]  dacr_q, dalg_q;
	logic                  vert_q;
	logic signed [33:0]    num_q;
	logic [33:0]           nmag_q;
	logic [31:0]           amag_q, dmag_q;
	logic                  qneg_q;
	logic [65:0]           prod_q, quo_q, best_q;
	logic [31:0]           rem_q;
	logic signed [32:0]    p_q, bx_q, by_q;
	logic                  inr_q, best_v_q, done_q;

	logic [ANG_W-1:0]      z_in, z_abs;
	logic signed [ZW-1:0]  zs, zf;
	logic [4:0]            ri;
	logic signed [CW-1:0]  xs, ys;
	logic signed [ZW-1:0]  at;
	logic [48:0]           pp;
	logic [32:0]           trial;
	logic                  ge;
	logic signed [66:0]    sq;
	logic signed [67:0]    qv;
	logic signed [CW-1:0]  dacr_abs, dalg_abs;
	logic signed [33:0]    num_abs;

	assign z_in  = {ray_angle, {SH{1'b0}}};
	assign z_abs = ray_angle[19] ? (~z_in + 1'b1) : z_in;

	assign zs = zneg_q ? -$signed(mag_q[ZW-1:0]) : $signed(mag_q[ZW-1:0]);
	always_comb begin
		if (zs > PI_Z) begin
			zf = zs - TPI_Z;
		end else if (zs < -PI_Z) begin
			zf = zs + TPI_Z;
		end else begin
			zf = zs;
		end
	end

	assign ri = cmd.step[4:0];
	assign xs = x_q >>> ri;
	assign ys = y_q >>> ri;
	assign at = ZW'(atan_q30(ri));

	assign pp = (cmd.op == OP_MUL0) ? (nmag_q[16:0] * amag_q) : (nmag_q[33:17] * amag_q);

	assign trial = {rem_q, quo_q[65]};
	assign ge    = trial >= {1'b0, dmag_q};

	assign sq = qneg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign qv = 68'(sq) + 68'(oalg_q);

	assign num_abs  = num_q[33] ? -num_q : num_q;
	assign dacr_abs = dacr_q[CW-1] ? -dacr_q : dacr_q;
	assign dalg_abs = dalg_q[CW-1] ? -dalg_q : dalg_q;

	assign stat.skip = (dacr_q == '0) ||
		(num_q < 0 && dacr_q > 0) || (num_q > 0 && dacr_q < 0);
	assign stat.inrange = inr_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				ox_q   <= origin_x;
				oy_q   <= origin_y;
				zneg_q <= ray_angle[19];
				mag_q  <= RW'(z_abs);
				div_q  <= DIV_INIT;
			end
			OP_RED: begin
				if (mag_q >= div_q) begin
					mag_q <= mag_q - div_q;
				end
				div_q <= div_q >> 1;
			end
			OP_FOLD: z_q <= zf;
			OP_HALF: begin
				if (z_q > HPI_Z) begin
					z_q    <= z_q - PI_Z;
					flip_q <= 1'b1;
				end else if (z_q < -HPI_Z) begin
					z_q    <= z_q + PI_Z;
					flip_q <= 1'b1;
				end else begin
					flip_q <= 1'b0;
				end
				x_q <= CW'(Q30_GAIN);
				y_q <= '0;
			end
			OP_ROT: begin
				if (z_q >= 0) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at;
				end
			end
			OP_FLIP: begin
				if (flip_q) begin
					x_q <= -x_q;
					y_q <= -y_q;
				end
				best_v_q <= 1'b0;
			end
			OP_EDGE: begin
				vert_q <= ~cmd.edge_sel[0];
				case (cmd.edge_sel)
					2'd0:    e_q <= xr;
					2'd1:    e_q <= yb;
					2'd2:    e_q <= xl;
					default: e_q <= yt;
				endcase
				if (!cmd.edge_sel[0]) begin
					lo_q   <= yb;
					hi_q   <= yt;
					oacr_q <= ox_q;
					oalg_q <= oy_q;
					dacr_q <= x_q;
					dalg_q <= y_q;
				end else begin
					lo_q   <= xl;
					hi_q   <= xr;
					oacr_q <= oy_q;
					oalg_q <= ox_q;
					dacr_q <= y_q;
					dalg_q <= x_q;
				end
			end
			OP_NUM: num_q <= 34'(e_q) - 34'(oacr_q);
			OP_CHK: begin
				nmag_q <= num_abs;
				amag_q <= dalg_abs[31:0];
				dmag_q <= dacr_abs[31:0];
				qneg_q <= num_q[33] ^ dalg_q[CW-1] ^ dacr_q[CW-1];
			end
			OP_MUL0: prod_q <= 66'(pp);
			OP_MUL1: prod_q <= prod_q + (66'(pp) << 17);
			OP_DQI: begin
				quo_q <= prod_q;
				rem_q <= '0;
			end
			OP_DTI: begin
				quo_q <= 66'(nmag_q) << 30;
				rem_q <= '0;
			end
			OP_DQ, OP_DT: begin
				rem_q <= ge ? 32'(trial - {1'b0, dmag_q}) : trial[31:0];
				quo_q <= {quo_q[64:0], ge};
			end
			OP_QCHK: begin
				inr_q <= (qv >= 68'(lo_q)) && (qv <= 68'(hi_q));
				p_q   <= qv[32:0];
			end
			OP_TDONE: begin
				if (!best_v_q || quo_q <= best_q) begin
					best_v_q <= 1'b1;
					best_q   <= quo_q;
					bx_q     <= vert_q ? e_q : p_q;
					by_q     <= vert_q ? p_q : e_q;
				end
			end
			OP_OUT: begin
				hit_valid <= best_v_q;
				if (best_v_q) begin
					hit_distance <= (|best_q[65:31]) ? 32'h7fff_ffff : best_q[31:0];
					hit_x        <= sat32(bx_q);
					hit_y        <= sat32(by_q);
				end else begin
					hit_distance <= NEG_ONE;
					hit_x        <= '0;
					hit_y        <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (cmd.op == OP_OUT);
		end
	end

	assign done = done_q;

endmodule
`default_nettype wire

// ===== bench/tb_ray_box_edge_hit_core.sv =====
`timescale 1ns / 100ps
module tb_ray_box_edge_hit_core;
	import rbeh_pkg::*;

	localparam logic [3:0] REG_UNUSED     = 4'd9;
	localparam longint ONE       = 64'sd65536;
	localparam int     CYCLE_CAP = 3000000;

	typedef struct {
		bit          hit;
		logic [31:0] dst;
		logic [31:0] px;
		logic [31:0] py;
	} hit_t;

	class hit_scoreboard;
		longint cx, cy, bw, bl;
		hit_t   pending[$];

		function new();
			cx = 0;
			cy = 0;
			bw = ONE;
			bl = ONE;
		endfunction

		function void write_reg(logic [3:0] idx, logic [31:0] val);
			case (idx)
				REG_CENTER_X:   cx = longint'(signed'(val));
				REG_CENTER_Y:   cy = longint'(signed'(val));
				REG_BOX_WIDTH:  bw = longint'({1'b0, val[30:0]});
				REG_BOX_LENGTH: bl = longint'({1'b0, val[30:0]});
				default: ;
			endcase
		endfunction

		function void direction(longint ang, output longint c, output longint s);
			longint x, y, z, xs, ys, at;
			bit flip;
			x = Q30_GAIN;
			y = 0;
			flip = 0;
			z = ang % Q30_TWO_PI;
			if (z > Q30_PI) z -= Q30_TWO_PI;
			else if (z < -Q30_PI) z += Q30_TWO_PI;
			if (z > Q30_HALF_PI) begin
				z -= Q30_PI;
				flip = 1;
			end else if (z < -Q30_HALF_PI) begin
				z += Q30_PI;
				flip = 1;
			end
			for (int i = 0; i < CORDIC_STEPS_DEF && i < 30; i++) begin
				case (i)
					0: at = 843314857;
					1: at = 497837829;
					2: at = 263043837;
					3: at = 133525159;
					4: at = 67021687;
					5: at = 33543516;
					6: at = 16775851;
					7: at = 8388437;
					8: at = 4194283;
					9: at = 2097149;
					default: at = 64'sd1 << (30 - i);
				endcase
				xs = x >>> i;
				ys = y >>> i;
				if (z >= 0) begin
					x -= ys;
					y += xs;
					z -= at;
				end else begin
					x += ys;
					y -= xs;
					z += at;
				end
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
		endfunction

		function bit cross_edge(longint e, longint lo, longint hi, longint o_across,
				longint o_along, longint d_across, longint d_along,
				output longint t, output longint p);
			longint num;
			num = e - o_across;
			t = 0;
			p = 0;
			if (d_across == 0) return 0;
			if ((num < 0 && d_across > 0) || (num > 0 && d_across < 0)) return 0;
			p = o_along + (num * d_along) / d_across;
			if (p < lo || p > hi) return 0;
			t = (num * (64'sd1 << 30)) / d_across;
			return 1;
		endfunction

		function longint clamp32(longint v);
			if (v > 64'sd2147483647) return 64'sd2147483647;
			if (v < -64'sd2147483648) return -64'sd2147483648;
			return v;
		endfunction

		function void note_ray(logic signed [31:0] ox, logic signed [31:0] oy,
				logic signed [19:0] ang);
			longint dx, dy, xr, xl, yt, yb, e, t, p, best, bx, by;
			bit found, got, vert;
			hit_t h;
			direction(longint'(ang) * 16384, dx, dy);
			xr = cx + (bl >>> 1);
			xl = cx - (bl >>> 1);
			yt = cy + (bw >>> 1);
			yb = cy - (bw >>> 1);
			found = 0;
			best = 0;
			bx = 0;
			by = 0;
			for (int k = 0; k < 4; k++) begin
				vert = (k % 2) == 0;
				e = (k == 0) ? xr : (k == 1) ? yb : (k == 2) ? xl : yt;
				if (vert) got = cross_edge(e, yb, yt, ox, oy, dx, dy, t, p);
				else got = cross_edge(e, xl, xr, oy, ox, dy, dx, t, p);
				if (got && !(found && best < t)) begin
					found = 1;
					best = t;
					bx = vert ? e : p;
					by = vert ? p : e;
				end
			end
			h.hit = found;
			if (found) begin
				h.dst = 32'(clamp32(best));
				h.px = 32'(clamp32(bx));
				h.py = 32'(clamp32(by));
			end else begin
				h.dst = 32'(-ONE);
				h.px = '0;
				h.py = '0;
			end
			pending.insert(pending.size(), h);
		endfunction

		function string check_hit(bit hv, logic [31:0] d, logic [31:0] x, logic [31:0] y);
			hit_t h;
			if (pending.size() == 0) return "result with no ray waiting";
			h = pending.pop_front();
			if (hv !== h.hit || d !== h.dst || x !== h.px || y !== h.py)
				return $sformatf("got hit=%0d d=%h x=%h y=%h, want hit=%0d d=%h x=%h y=%h",
					hv, d, x, y, h.hit, h.dst, h.px, h.py);
			return "";
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic signed [31:0] origin_x;
	logic signed [31:0] origin_y;
	logic signed [19:0] ray_angle;
	logic               done;
	logic               hit_valid;
	logic signed [31:0] hit_distance;
	logic signed [31:0] hit_x;
	logic signed [31:0] hit_y;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [3:0]         cfg_index;
	logic [31:0]        cfg_data;

	hit_scoreboard sb = new();
	int  errors = 0;
	int  rays_taken = 0;
	int  cfg_taken = 0;
	int  cycles = 0;
	bit  no_gaps = 0;

	ray_box_edge_hit_core u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.origin_x(origin_x), .origin_y(origin_y), .ray_angle(ray_angle),
		.done(done), .hit_valid(hit_valid), .hit_distance(hit_distance),
		.hit_x(hit_x), .hit_y(hit_y), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report(string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		errors++;
	endtask

	always @(posedge clk) begin
		string msg;
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("*** FAILED ***");
			$finish;
		end
		if (arst_n) begin
			if (start && !busy) begin
				sb.note_ray(origin_x, origin_y, ray_angle);
				rays_taken <= rays_taken + 1;
			end
			if (done) begin
				msg = sb.check_hit(hit_valid, hit_distance, hit_x, hit_y);
				if (msg.len() > 0) report(msg);
			end
			if (cfg_valid && cfg_ready) begin
				sb.write_reg(cfg_index, cfg_data);
				cfg_taken <= cfg_taken + 1;
			end
		end
	end

	task automatic drain();
		start <= 1'b0;
		while (sb.pending.size() != 0 || busy) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic send_ray(logic [31:0] ox, logic [31:0] oy, logic [19:0] ang);
		int gap;
		int seen;
		gap = no_gaps ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		seen = rays_taken;
		start <= 1'b1;
		origin_x <= ox;
		origin_y <= oy;
		ray_angle <= ang;
		do @(negedge clk); while (rays_taken == seen);
	endtask

	task automatic write_reg(logic [3:0] idx, logic [31:0] val);
		int seen;
		seen = cfg_taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (cfg_taken == seen);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_box(logic [31:0] cx, logic [31:0] cy, logic [31:0] w, logic [31:0] l);
		start <= 1'b0;
		drain();
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_BOX_WIDTH, w);
		write_reg(REG_BOX_LENGTH, l);
		write_reg(REG_UNUSED, $urandom());
	endtask

	task automatic random_rays(int count);
		longint span, ox, oy;
		logic [19:0] ang;
		for (int i = 0; i < count; i++) begin
			span = (sb.bw > sb.bl ? sb.bw : sb.bl) + 4 * ONE;
			if (span > 64'sd1000000000) span = 64'sd1000000000;
			if ($urandom_range(0, 99) < 85) begin
				ox = sb.cx + longint'($urandom_range(0, 32'(2 * span))) - span;
				oy = sb.cy + longint'($urandom_range(0, 32'(2 * span))) - span;
			end else begin
				ox = $urandom();
				oy = $urandom();
			end
			if ($urandom_range(0, 99) < 80)
				ang = 20'($signed($urandom_range(0, 823550)) - 411775);
			else
				ang = 20'($urandom());
			if (i % 200 == 100) drain();
			send_ray(32'(ox), 32'(oy), ang);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		origin_x = '0;
		origin_y = '0;
		ray_angle = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_ray(0, 0, 0);
		send_ray(32'(-2 * ONE), 0, 0);
		send_ray(32'(-2 * ONE), 0, 20'sd205887);
		send_ray(32'(-2 * ONE), 0, -20'sd205887);
		send_ray(0, 32'(-3 * ONE), 20'sd102944);
		send_ray(0, 32'(3 * ONE), -20'sd102944);
		send_ray(32'(-ONE), 32'(-ONE), 20'sd51472);
		send_ray(32'(ONE / 2), 0, 0);
		send_ray(32'(ONE / 2), 32'(ONE / 2), 20'sd51472);
		send_ray(32'(-2 * ONE), 32'(ONE / 2), 0);
		send_ray(32'h8000_0000, 32'h8000_0000, 20'sd51472);
		send_ray(32'h7fff_ffff, 32'h7fff_ffff, -20'sd154415);
		send_ray(32'h7fff_ffff, 0, 20'sd205887);
		send_ray(0, 0, 20'sd411775);
		send_ray(0, 0, -20'sd411775);
		send_ray(0, 0, 20'h80000);
		send_ray(0, 0, 20'h7ffff);
		send_ray(32'(3 * ONE), 32'(3 * ONE), 20'sd51472);
		send_ray(32'(-3 * ONE), 32'(ONE), 0);
		send_ray(0, 32'(-ONE), 20'sd102944);

		random_rays(200);
		set_box(32'(5 * ONE), 32'(-7 * ONE), 32'(3 * ONE), 32'(8 * ONE + 1));
		random_rays(100);
		no_gaps = 1;
		set_box($urandom_range(0, 32'h000f_ffff), $urandom(), $urandom_range(0, 32'h0010_0000),
			32'h8000_0000 | $urandom_range(0, 32'h0010_0000));
		random_rays(110);
		no_gaps = 0;
		set_box(32'(ONE), 32'(ONE), 0, 32'(2 * ONE));
		random_rays(90);
		set_box(0, 0, 0, 0);
		send_ray(0, 0, 0);
		send_ray(32'(-ONE), 0, 0);
		random_rays(60);
		set_box(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff);
		random_rays(90);
		set_box(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
		random_rays(90);
		set_box($urandom(), $urandom(), $urandom(), $urandom());
		random_rays(90);

		start <= 1'b0;
		drain();
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
